@@ hdl/fifous_pkg.sv @@
// ----------------------------------------------------------------------------
// fifous_pkg
// Shared types and constants for the circular FIFO with usage statistics.
// ----------------------------------------------------------------------------
`default_nettype none

package fifous_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int WORD_BITS_DEFAULT = 32;
   localparam int DATA_W            = 32;   // width of push_word / pop_word
   localparam int LEVEL_W           = 4;    // width of fill_level / peak_fill
   localparam int STAT_W            = 32;   // width of the wrapping counters

   typedef enum logic [1:0] {
      ACT_PUSH   = 2'd0,
      ACT_POP    = 2'd1,
      ACT_STATUS = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef struct packed {
      action_type          action;
      logic [DATA_W-1:0]   push_word;
   } req_type;

   typedef struct packed {
      logic                accepted;
      logic [DATA_W-1:0]   pop_word;
      logic [LEVEL_W-1:0]  fill_level;
      logic                is_empty;
      logic                is_full;
      logic [STAT_W-1:0]   pushes_total;
      logic [STAT_W-1:0]   pops_total;
      logic [STAT_W-1:0]   overflows_total;
      logic [LEVEL_W-1:0]  peak_fill;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/fifous_ram.sv @@
// ----------------------------------------------------------------------------
// fifous_ram
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fifous_ram import fifous_pkg::*; #(
   parameter int DEPTH  = DEPTH_DEFAULT,
   parameter int WIDTH  = WORD_BITS_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read, so it can sit behind a stalled output
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/fifo_with_usage_statistics_top.sv @@
// Timing: a result is offered in the cycle after its word is accepted.
// Throughput: one word per cycle; the single output register and the registered
// read of the slot RAM set this, and a word is taken whenever that register is
// empty or being drained in the same cycle.
// Reset: synchronous; pointers, fill count, peak and counters clear at once,
// the slot RAM is not cleared (no slot is read before it is written).
// ----------------------------------------------------------------------------
// fifo_with_usage_statistics_top
// Circular FIFO with one spare slot, push/pop/overflow counters and peak fill.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_with_usage_statistics_top import fifous_pkg::*; #(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [PTR_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  peak_ff, peak_in;
   logic [STAT_W-1:0] push_cnt_ff, push_cnt_in;
   logic [STAT_W-1:0] pop_cnt_ff, pop_cnt_in;
   logic [STAT_W-1:0] ovf_cnt_ff, ovf_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              pop_sel_ff, pop_sel_in;
   rsp_type           rsp_info_ff, rsp_info_in;

   logic                 accept;
   logic [WORD_BITS-1:0] word;
   logic                 push_ok;
   logic                 pop_ok;
   logic [WORD_BITS-1:0] rd_data;

   assign req_stall = reset || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign word      = WORD_BITS'(req_data.push_word);

   always_comb begin
      push_ok     = 1'b0;
      pop_ok      = 1'b0;
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      count_in    = count_ff;
      peak_in     = peak_ff;
      push_cnt_in = push_cnt_ff;
      pop_cnt_in  = pop_cnt_ff;
      ovf_cnt_in  = ovf_cnt_ff;
      if (accept) begin
         case (req_data.action)
            ACT_PUSH: begin
               if (word != '0) begin
                  if (count_ff == LAST_SLOT) begin
                     ovf_cnt_in = ovf_cnt_ff + 1'b1;
                  end else begin
                     push_ok     = 1'b1;
                     wp_in       = (wp_ff == LAST_SLOT) ? '0 : wp_ff + 1'b1;
                     count_in    = count_ff + 1'b1;
                     push_cnt_in = push_cnt_ff + 1'b1;
                     if (count_in > peak_ff) begin
                        peak_in = count_in;
                     end
                  end
               end
            end
            ACT_POP: begin
               if (count_ff != '0) begin
                  pop_ok     = 1'b1;
                  rp_in      = (rp_ff == LAST_SLOT) ? '0 : rp_ff + 1'b1;
                  count_in   = count_ff - 1'b1;
                  pop_cnt_in = pop_cnt_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // output register: everything but the popped word, which lands from the RAM
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop_sel_in   = pop_sel_ff;
      rsp_info_in  = rsp_info_ff;
      if (accept) begin
         rsp_valid_in                = 1'b1;
         pop_sel_in                  = pop_ok;
         rsp_info_in.accepted        = push_ok || pop_ok;
         rsp_info_in.pop_word        = '0;
         rsp_info_in.fill_level      = LEVEL_W'(count_in);
         rsp_info_in.is_empty        = (count_in == '0);
         rsp_info_in.is_full         = (count_in == LAST_SLOT);
         rsp_info_in.pushes_total    = push_cnt_in;
         rsp_info_in.pops_total      = pop_cnt_in;
         rsp_info_in.overflows_total = ovf_cnt_in;
         rsp_info_in.peak_fill       = LEVEL_W'(peak_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         count_ff     <= '0;
         peak_ff      <= '0;
         push_cnt_ff  <= '0;
         pop_cnt_ff   <= '0;
         ovf_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         count_ff     <= count_in;
         peak_ff      <= peak_in;
         push_cnt_ff  <= push_cnt_in;
         pop_cnt_ff   <= pop_cnt_in;
         ovf_cnt_ff   <= ovf_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_sel_ff  <= pop_sel_in;
      rsp_info_ff <= rsp_info_in;
   end

   fifous_ram #(
      .DEPTH  (DEPTH),
      .WIDTH  (WORD_BITS),
      .ADDR_W (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push_ok),
      .wr_addr (wp_ff),
      .wr_data (word),
      .rd_en   (pop_ok),
      .rd_addr (rp_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_data          = rsp_info_ff;
      rsp_data.pop_word = pop_sel_ff ? DATA_W'(rd_data) : '0;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hdl/fifous_checker.sv @@
// ----------------------------------------------------------------------------
// fifous_checker
// Port-level checks for the FIFO with usage statistics, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module fifous_checker import fifous_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // a stalled result word stays offered
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // every accepted request gives a result on the next cycle
   a_one_result : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no result");

   a_flags : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_empty && rsp_data.is_full))
      else $error("queue reported empty and full at once");

   a_no_data : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.accepted |-> rsp_data.pop_word == '0)
      else $error("pop_word nonzero on a rejected word");

endmodule

bind fifo_with_usage_statistics_top fifous_checker u_checker (.*);

`default_nettype wire
